FILE: rtl/core/assert_macros.svh
// assertion macros used by the header line parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/core/hhlp_pkg.sv
// package: phase, role and event codes, byte constants and result type of the header parser
package hhlp_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_NAME    = 3'd0,
        PH_NAME_CR = 3'd1,
        PH_SEP     = 3'd2,
        PH_VALUE   = 3'd3,
        PH_VAL_CR  = 3'd4,
        PH_VAL_LF  = 3'd5,
        PH_FOLD    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_SKIP  = 2'd0,
        ROLE_NAME  = 2'd1,
        ROLE_VALUE = 2'd2
    } t_role;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DONE  = 3'd1,
        EV_EMPTY = 3'd2,
        EV_END   = 3'd3,
        EV_ERR   = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0] out_byte;
        t_role      byte_role;
        t_event     event_res;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_COLON) || is_ws(b);
    endfunction

endpackage

FILE: rtl/core/hhlp_ifs.sv
// valid/ready channel interfaces for header bytes in and parsed beats out
interface hhlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hhlp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_role;
    logic [2:0] event_res;

    modport source (output valid, output out_byte, output byte_role, output event_res,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_role, input event_res,
                    output ready);
endinterface

FILE: rtl/core/http_header_line_parser.sv
// http_header_line_parser: sorts HTTP header text into name and value bytes, one byte a beat.
// Each input beat gives exactly one output beat. Throughput is one byte per clock cycle while
// the output is not stalled, set by the single phase register that is updated as a byte moves
// from the input register to the result register, which drives the output beat. While a
// result waits at a stalled output the input register takes one more byte and then holds
// ready low until the output moves, so one byte of slack is held on each side. Outputs:
// out_byte (0x20 at a fold), byte_role (0 skip, 1 name, 2 value), event_res (0 none,
// 1 header done, 2 empty line, 3 text end, 4 error).
`include "assert_macros.svh"

module http_header_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hhlp_in_if.sink     i_in,
    hhlp_out_if.source  o_out
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    hhlp_pkg::t_result r_out;
    hhlp_pkg::t_phase  r_phase;

    hhlp_pkg::t_phase  n_phase;
    hhlp_pkg::t_result n_out;
    logic              w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    hhlp_step u_step (
        .i_phase      (r_phase),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_next_phase (n_phase),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= hhlp_pkg::PH_NAME;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out.out_byte;
    assign o_out.byte_role = r_out.byte_role;
    assign o_out.event_res = r_out.event_res;

    // end of text always returns to the name phase
    `ASSERT_NEXT(a_last_to_name, i_clk, i_rst_n, w_adv && r_in_last,
                 r_phase == hhlp_pkg::PH_NAME)
    // an error beat never carries a name or value byte
    `ASSERT_IMPL(a_err_skip, i_clk, i_rst_n,
                 r_out_valid && (r_out.event_res == hhlp_pkg::EV_ERR),
                 r_out.byte_role == hhlp_pkg::ROLE_SKIP)
    // a held input byte is not overwritten
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv,
                 r_in_valid && $stable(r_in_byte) && $stable(r_in_last))

endmodule

FILE: rtl/core/hhlp_step.sv
// one-byte decision logic: current phase and byte in, next phase and result out
module hhlp_step (
    input  hhlp_pkg::t_phase  i_phase,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output hhlp_pkg::t_phase  o_next_phase,
    output hhlp_pkg::t_result o_result
);

    hhlp_pkg::t_phase name_phase;
    hhlp_pkg::t_role  name_role;
    hhlp_pkg::t_phase value_phase;
    hhlp_pkg::t_role  value_role;
    hhlp_pkg::t_phase phase_nxt;
    hhlp_pkg::t_role  role;
    hhlp_pkg::t_event ev;
    logic [7:0]       ob;

    // name phase handling of one byte
    always_comb begin
        if (hhlp_pkg::is_sep(i_data_byte)) begin
            name_phase = hhlp_pkg::PH_SEP;
            name_role  = hhlp_pkg::ROLE_SKIP;
        end else if (i_data_byte == hhlp_pkg::CH_CR) begin
            name_phase = hhlp_pkg::PH_NAME_CR;
            name_role  = hhlp_pkg::ROLE_SKIP;
        end else begin
            name_phase = hhlp_pkg::PH_NAME;
            name_role  = hhlp_pkg::ROLE_NAME;
        end
    end

    // value phase handling of one byte
    always_comb begin
        if (i_data_byte == hhlp_pkg::CH_CR) begin
            value_phase = hhlp_pkg::PH_VAL_CR;
            value_role  = hhlp_pkg::ROLE_SKIP;
        end else begin
            value_phase = hhlp_pkg::PH_VALUE;
            value_role  = hhlp_pkg::ROLE_VALUE;
        end
    end

    always_comb begin
        phase_nxt = hhlp_pkg::PH_NAME;
        role      = hhlp_pkg::ROLE_SKIP;
        ev        = hhlp_pkg::EV_NONE;
        ob        = i_data_byte;
        case (i_phase)
            hhlp_pkg::PH_NAME_CR: begin
                ev = (i_data_byte == hhlp_pkg::CH_LF) ? hhlp_pkg::EV_EMPTY : hhlp_pkg::EV_ERR;
                phase_nxt = hhlp_pkg::PH_NAME;
            end
            hhlp_pkg::PH_SEP: begin
                if (hhlp_pkg::is_sep(i_data_byte)) begin
                    phase_nxt = hhlp_pkg::PH_SEP;
                end else begin
                    phase_nxt = value_phase;
                    role      = value_role;
                end
            end
            hhlp_pkg::PH_VALUE: begin
                phase_nxt = value_phase;
                role      = value_role;
            end
            hhlp_pkg::PH_VAL_CR: begin
                if (i_data_byte == hhlp_pkg::CH_LF) begin
                    phase_nxt = hhlp_pkg::PH_VAL_LF;
                end else begin
                    ev        = hhlp_pkg::EV_ERR;
                    phase_nxt = hhlp_pkg::PH_NAME;
                end
            end
            hhlp_pkg::PH_VAL_LF: begin
                if (hhlp_pkg::is_ws(i_data_byte)) begin
                    // fold: one value space, rest of the whitespace skipped
                    ob        = hhlp_pkg::CH_SP;
                    role      = hhlp_pkg::ROLE_VALUE;
                    phase_nxt = hhlp_pkg::PH_FOLD;
                end else begin
                    ev        = hhlp_pkg::EV_DONE;
                    phase_nxt = name_phase;
                    role      = name_role;
                end
            end
            hhlp_pkg::PH_FOLD: begin
                if (hhlp_pkg::is_ws(i_data_byte)) begin
                    phase_nxt = hhlp_pkg::PH_FOLD;
                end else begin
                    phase_nxt = value_phase;
                    role      = value_role;
                end
            end
            default: begin
                phase_nxt = name_phase;
                role      = name_role;
            end
        endcase

        // end of text overrides
        if (i_last_byte) begin
            if ((phase_nxt == hhlp_pkg::PH_NAME_CR) || (phase_nxt == hhlp_pkg::PH_VAL_CR)) begin
                ev = hhlp_pkg::EV_ERR;
            end else if (ev == hhlp_pkg::EV_NONE) begin
                ev = hhlp_pkg::EV_END;
            end
            phase_nxt = hhlp_pkg::PH_NAME;
        end
    end

    assign o_next_phase       = phase_nxt;
    assign o_result.out_byte  = ob;
    assign o_result.byte_role = role;
    assign o_result.event_res = ev;

endmodule
